/* src/ilda_laser_frame_stream_parser_assert.svh */
// assertion macros for the ilda stream parser
// no dependencies; included by the top level only
`ifndef ILDA_LASER_FRAME_STREAM_PARSER_ASSERT_SVH
`define ILDA_LASER_FRAME_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define ILDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ilda parser assertion failed");
`define ILDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ilda parser assertion failed");
`else
`define ILDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ILDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/ilda_pkg.sv */
// types, codes and colour tables of the ilda stream parser
// no dependencies; used by the top level
package ilda_pkg;

	localparam int PROJECTORS      = 4;
	localparam int PALETTE_ENTRIES = 256;
	localparam int DEFAULT_ENTRIES = 64;
	localparam int STD_ENTRIES     = 64;

	localparam int PROJ_W    = $clog2(PROJECTORS);
	localparam int IDX_W     = $clog2(PALETTE_ENTRIES);
	localparam int PAL_DEPTH = PROJECTORS * PALETTE_ENTRIES;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_HEADER,
		PH_RECORDS,
		PH_HALT
	} phase_t;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [31:0] FMT_3D_INDEXED = 32'd0;
	localparam logic [31:0] FMT_2D_INDEXED = 32'd1;
	localparam logic [31:0] FMT_PALETTE    = 32'd2;
	localparam logic [31:0] FMT_3D_TRUE    = 32'd4;
	localparam logic [31:0] FMT_2D_TRUE    = 32'd5;

	localparam logic [23:0] SIG_PREFIX = 24'h494C44;
	localparam logic [7:0]  SIG_LAST   = 8'h41;
	localparam int          BLANK_BIT  = 6;
	localparam logic [23:0] WHITE      = 24'hFFFFFF;

	localparam logic [4:0] HDR_FMT_END   = 5'd4;
	localparam logic [4:0] HDR_COUNT_HI  = 5'd20;
	localparam logic [4:0] HDR_COUNT_LO  = 5'd21;
	localparam logic [4:0] HDR_FRAME_HI  = 5'd22;
	localparam logic [4:0] HDR_FRAME_LO  = 5'd23;
	localparam logic [4:0] HDR_TOTAL_HI  = 5'd24;
	localparam logic [4:0] HDR_TOTAL_LO  = 5'd25;
	localparam logic [4:0] HDR_PROJ      = 5'd26;
	localparam logic [4:0] HDR_LAST      = 5'd27;
	localparam logic [4:0] REC_BUF_BYTES = 5'd9;

	localparam logic [23:0] STD_COLOURS [STD_ENTRIES] = '{
		24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000, 24'hFF4000, 24'hFF5000,
		24'hFF6000, 24'hFF7000, 24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000,
		24'hFFC000, 24'hFFD000, 24'hFFE000, 24'hFFF000, 24'hFFFF00, 24'hE0FF00,
		24'hC0FF00, 24'hA0FF00, 24'h80FF00, 24'h60FF00, 24'h40FF00, 24'h20FF00,
		24'h00FF00, 24'h00FF24, 24'h00FF49, 24'h00FF6D, 24'h00FF92, 24'h00FFB6,
		24'h00FFDB, 24'h00FFFF, 24'h00E3FF, 24'h00C6FF, 24'h00AAFF, 24'h008EFF,
		24'h0071FF, 24'h0055FF, 24'h0038FF, 24'h001CFF, 24'h0000FF, 24'h2000FF,
		24'h4000FF, 24'h6000FF, 24'h8000FF, 24'hA000FF, 24'hC000FF, 24'hE000FF,
		24'hFF00FF, 24'hFF20FF, 24'hFF40FF, 24'hFF60FF, 24'hFF80FF, 24'hFFA0FF,
		24'hFFC0FF, 24'hFFE0FF, 24'hFFFFFF, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0,
		24'hFF8080, 24'hFF6060, 24'hFF4040, 24'hFF2020
	};

	// reset colour of one palette entry
	function automatic logic [23:0] default_colour(input logic [IDX_W-1:0] idx);
		logic [23:0] c;
		c = WHITE;
		if ({1'b0, idx} < (IDX_W+1)'(DEFAULT_ENTRIES) && {1'b0, idx} < (IDX_W+1)'(STD_ENTRIES))
			c = STD_COLOURS[idx[5:0]];
		return c;
	endfunction

	function automatic logic [3:0] rec_size(input logic [31:0] fmt);
		logic [3:0] s;
		case (fmt)
			FMT_3D_INDEXED: s = 4'd8;
			FMT_2D_INDEXED: s = 4'd6;
			FMT_PALETTE:    s = 4'd3;
			FMT_3D_TRUE:    s = 4'd10;
			default:        s = 4'd8;
		endcase
		return s;
	endfunction

	// projector byte modulo PROJECTORS, restoring compare and subtract
	function automatic logic [PROJ_W-1:0] proj_wrap(input logic [7:0] b);
		logic [16:0] rem;
		logic [16:0] step;
		rem = {9'd0, b};
		for (int k = 7; k >= 0; k--) begin
			step = 17'(PROJECTORS) << k;
			if (rem >= step)
				rem = rem - step;
		end
		return rem[PROJ_W-1:0];
	endfunction

	function automatic logic known_format(input logic [31:0] fmt);
		return fmt == FMT_3D_INDEXED || fmt == FMT_2D_INDEXED || fmt == FMT_PALETTE ||
			fmt == FMT_3D_TRUE || fmt == FMT_2D_TRUE;
	endfunction

endpackage

/* src/ilda_ram.sv */
// generic single write port ram with registered read and read enable
// no dependencies
module ilda_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

/* src/ilda_laser_frame_stream_parser.sv */
// ilda stream parser: one byte item per cycle while in_stall is low
// a result passes the palette ram read register (stage 1), then the output register, after its
// byte is accepted; throughput one byte per cycle while in_stall is low
// reset: asynchronous clear of control state, then a palette fill of all PROJECTORS*PALETTE_ENTRIES
// entries (1024) with default colours, one entry a cycle, with in_stall held high
`include "ilda_laser_frame_stream_parser_assert.svh"
module ilda_laser_frame_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic signed [15:0] coord_x,
	output logic signed [15:0] coord_y,
	output logic signed [15:0] coord_z,
	output logic        blanked,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] frame_index,
	output logic [15:0] frame_total,
	output logic [1:0]  projector_id,
	output logic        last_in_frame
);

	localparam int PROJ_W = ilda_pkg::PROJ_W;
	localparam int IDX_W  = ilda_pkg::IDX_W;
	localparam int PAL_AW = ilda_pkg::PAL_AW;

	// parser state
	ilda_pkg::phase_t phase_q, phase_d;
	logic [23:0] sig_q, sig_d;
	logic [4:0]  pos_q, pos_d;
	logic [31:0] fmt_q, fmt_d;
	logic [15:0] rec_total_q, rec_total_d;
	logic [15:0] rec_num_q, rec_num_d;
	logic [15:0] frame_num_q, frame_num_d;
	logic [15:0] frame_tot_q, frame_tot_d;
	logic [PROJ_W-1:0] proj_q, proj_d;
	logic [7:0]  rec_q [9];
	logic        rec_we;

	// palette fill after reset
	logic              clearing_q;
	logic [PAL_AW-1:0] clr_cnt_q;

	// per-item results of the combinational pass
	logic        in_accept;
	logic        emit;
	logic [1:0]  e_kind;
	logic [15:0] e_x, e_y, e_z;
	logic        e_blank;
	logic [23:0] e_rgb;
	logic        e_use_pal;
	logic        e_last;
	logic        pal_we, pal_rd;
	logic [PAL_AW-1:0] pal_waddr, pal_raddr;
	logic [23:0] pal_wdata;
	logic [3:0]  size;
	logic        is_last;

	// pipeline
	logic        valid_s1, valid_s2, out_free;
	logic [1:0]  kind_s1, kind_s2;
	logic [15:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic        blank_s1, blank_s2, last_s1, last_s2, use_pal_s1;
	logic [23:0] rgb_s1, rgb_s2;
	logic [15:0] fnum_s1, ftot_s1, fnum_s2, ftot_s2;
	logic [PROJ_W-1:0] proj_s1, proj_s2;

	logic              ram_we;
	logic [PAL_AW-1:0] ram_waddr;
	logic [23:0]       ram_wdata, ram_rdata;

	assign out_free  = !valid_s2 || !out_stall;
	assign in_stall  = clearing_q || (valid_s1 && !out_free);
	assign in_accept = in_valid && !in_stall;

	assign size    = ilda_pkg::rec_size(fmt_q);
	assign is_last = ({1'b0, rec_num_q} + 17'd1) == {1'b0, rec_total_q};

	always_comb begin
		phase_d     = phase_q;
		sig_d       = sig_q;
		pos_d       = pos_q;
		fmt_d       = fmt_q;
		rec_total_d = rec_total_q;
		rec_num_d   = rec_num_q;
		frame_num_d = frame_num_q;
		frame_tot_d = frame_tot_q;
		proj_d      = proj_q;
		rec_we      = 1'b0;
		emit        = 1'b0;
		e_kind      = ilda_pkg::KIND_POINT;
		e_x         = 16'd0;
		e_y         = 16'd0;
		e_z         = 16'd0;
		e_blank     = 1'b0;
		e_rgb       = 24'd0;
		e_use_pal   = 1'b0;
		e_last      = 1'b0;
		pal_we      = 1'b0;
		pal_rd      = 1'b0;
		pal_waddr   = {proj_q, rec_num_q[IDX_W-1:0]};
		pal_raddr   = {proj_q, data_byte[IDX_W-1:0]};
		pal_wdata   = {rec_q[0], rec_q[1], data_byte};
		if (in_accept) begin
			case (phase_q)
				ilda_pkg::PH_SEEK: begin
					if (sig_q == ilda_pkg::SIG_PREFIX && data_byte == ilda_pkg::SIG_LAST) begin
						phase_d     = ilda_pkg::PH_HEADER;
						pos_d       = 5'd0;
						fmt_d       = 32'd0;
						rec_total_d = 16'd0;
						frame_num_d = 16'd0;
						frame_tot_d = 16'd0;
						proj_d      = '0;
					end
					sig_d = {sig_q[15:0], data_byte};
				end
				ilda_pkg::PH_HEADER: begin
					if (pos_q < ilda_pkg::HDR_FMT_END)
						fmt_d = {fmt_q[23:0], data_byte};
					else if (pos_q == ilda_pkg::HDR_COUNT_HI || pos_q == ilda_pkg::HDR_COUNT_LO)
						rec_total_d = {rec_total_q[7:0], data_byte};
					else if (pos_q == ilda_pkg::HDR_FRAME_HI || pos_q == ilda_pkg::HDR_FRAME_LO)
						frame_num_d = {frame_num_q[7:0], data_byte};
					else if (pos_q == ilda_pkg::HDR_TOTAL_HI || pos_q == ilda_pkg::HDR_TOTAL_LO)
						frame_tot_d = {frame_tot_q[7:0], data_byte};
					else if (pos_q == ilda_pkg::HDR_PROJ)
						proj_d = ilda_pkg::proj_wrap(data_byte);
					if (pos_q != ilda_pkg::HDR_LAST) begin
						pos_d = pos_q + 5'd1;
					end else begin
						pos_d = 5'd0;
						if (!ilda_pkg::known_format(fmt_q)) begin
							phase_d = ilda_pkg::PH_HALT;
							emit    = 1'b1;
							e_kind  = ilda_pkg::KIND_ERROR;
						end else if (rec_total_q == 16'd0) begin
							phase_d = ilda_pkg::PH_HALT;
							emit    = 1'b1;
							e_kind  = ilda_pkg::KIND_END;
						end else begin
							phase_d   = ilda_pkg::PH_RECORDS;
							rec_num_d = 16'd0;
						end
					end
				end
				ilda_pkg::PH_RECORDS: begin
					if ((6'(pos_q) + 6'd1) < 6'(size) && pos_q < ilda_pkg::REC_BUF_BYTES) begin
						rec_we = 1'b1;
						pos_d  = pos_q + 5'd1;
					end else begin
						// final byte of the record
						e_x    = {rec_q[0], rec_q[1]};
						e_y    = {rec_q[2], rec_q[3]};
						e_last = is_last;
						if (fmt_q == ilda_pkg::FMT_PALETTE) begin
							pal_we = {16'd0, rec_num_q} < 32'(ilda_pkg::PALETTE_ENTRIES);
						end else begin
							emit = 1'b1;
							case (fmt_q)
								ilda_pkg::FMT_3D_INDEXED: begin
									e_z       = {rec_q[4], rec_q[5]};
									e_blank   = rec_q[6][ilda_pkg::BLANK_BIT];
									e_use_pal = 1'b1;
								end
								ilda_pkg::FMT_2D_INDEXED: begin
									e_blank   = rec_q[4][ilda_pkg::BLANK_BIT];
									e_use_pal = 1'b1;
								end
								ilda_pkg::FMT_3D_TRUE: begin
									e_z     = {rec_q[4], rec_q[5]};
									e_blank = rec_q[6][ilda_pkg::BLANK_BIT];
									e_rgb   = {data_byte, rec_q[8], rec_q[7]};
								end
								default: begin
									e_blank = rec_q[4][ilda_pkg::BLANK_BIT];
									e_rgb   = {data_byte, rec_q[6], rec_q[5]};
								end
							endcase
							// colour index beyond the palette reads as white
							if (e_use_pal &&
								{1'b0, data_byte} >= 9'(ilda_pkg::PALETTE_ENTRIES)) begin
								e_use_pal = 1'b0;
								e_rgb     = ilda_pkg::WHITE;
							end
							pal_rd = e_use_pal;
						end
						pos_d     = 5'd0;
						rec_num_d = rec_num_q + 16'd1;
						if (is_last) begin
							phase_d = ilda_pkg::PH_SEEK;
							sig_d   = 24'd0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ilda_pkg::PH_SEEK;
			sig_q       <= 24'd0;
			pos_q       <= 5'd0;
			fmt_q       <= 32'd0;
			rec_total_q <= 16'd0;
			rec_num_q   <= 16'd0;
			frame_num_q <= 16'd0;
			frame_tot_q <= 16'd0;
			proj_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			sig_q       <= sig_d;
			pos_q       <= pos_d;
			fmt_q       <= fmt_d;
			rec_total_q <= rec_total_d;
			rec_num_q   <= rec_num_d;
			frame_num_q <= frame_num_d;
			frame_tot_q <= frame_tot_d;
			proj_q      <= proj_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_q[pos_q[3:0]] <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + PAL_AW'(1);
			if (clr_cnt_q == PAL_AW'(ilda_pkg::PAL_DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	assign ram_we    = clearing_q || pal_we;
	assign ram_waddr = clearing_q ? clr_cnt_q : pal_waddr;
	assign ram_wdata = clearing_q ? ilda_pkg::default_colour(clr_cnt_q[IDX_W-1:0]) : pal_wdata;

	ilda_ram #(
		.WIDTH (24),
		.DEPTH (ilda_pkg::PAL_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (pal_rd),
		.rd_addr (pal_raddr),
		.rd_data (ram_rdata)
	);

	// stage 1 waits on the palette read, stage 2 is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (emit)
				valid_s1 <= 1'b1;
			else if (out_free)
				valid_s1 <= 1'b0;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_s1    <= e_kind;
			x_s1       <= e_x;
			y_s1       <= e_y;
			z_s1       <= e_z;
			blank_s1   <= e_blank;
			rgb_s1     <= e_rgb;
			use_pal_s1 <= e_use_pal;
			last_s1    <= e_last;
			fnum_s1    <= frame_num_q;
			ftot_s1    <= frame_tot_q;
			proj_s1    <= proj_q;
		end
		if (out_free && valid_s1) begin
			kind_s2  <= kind_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			blank_s2 <= blank_s1;
			rgb_s2   <= use_pal_s1 ? ram_rdata : rgb_s1;
			last_s2  <= last_s1;
			fnum_s2  <= fnum_s1;
			ftot_s2  <= ftot_s1;
			proj_s2  <= proj_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign result_kind   = kind_s2;
	assign coord_x       = x_s2;
	assign coord_y       = y_s2;
	assign coord_z       = z_s2;
	assign blanked       = blank_s2;
	assign red           = rgb_s2[23:16];
	assign green         = rgb_s2[15:8];
	assign blue          = rgb_s2[7:0];
	assign frame_index   = fnum_s2;
	assign frame_total   = ftot_s2;
	assign projector_id  = proj_s2;
	assign last_in_frame = last_s2;

	`ILDA_ASSERT_NEXT(a_halt_sticks, clk, arst_n, phase_q == ilda_pkg::PH_HALT, phase_q == ilda_pkg::PH_HALT)
	`ILDA_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && valid_s2 && out_stall, valid_s1 && $stable(x_s1))
	`ILDA_ASSERT_IMPLY(a_pos_in_record, clk, arst_n, phase_q == ilda_pkg::PH_RECORDS, pos_q < 5'(ilda_pkg::rec_size(fmt_q)))
	`ILDA_ASSERT_IMPLY(a_fill_quiet, clk, arst_n, clearing_q, !valid_s1 && !valid_s2 && phase_q == ilda_pkg::PH_SEEK)

endmodule
